>>> rtl/sawarq_pkg.sv
// Shared types, codes and constants of the stop-and-wait ARQ endpoint.
package sawarq_pkg;

  localparam logic [7:0] PACKET_BYTES = 8'd32;
  localparam logic [8:0] ID_WRAP = 9'd250;
  localparam logic [7:0] ID_BASE = 8'd1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd20;
  localparam logic [7:0] ACKS_RESET = 8'd10;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SEND = 2'd1;
  localparam logic [1:0] REQ_RECV = 2'd2;

  localparam logic [1:0] LINK_IDLE = 2'd0;
  localparam logic [1:0] LINK_ERROR = 2'd2;

  localparam logic [2:0] ST_TX_IDLE = 3'd0;
  localparam logic [2:0] ST_TX_SEND = 3'd1;
  localparam logic [2:0] ST_TX_ACK = 3'd2;
  localparam logic [2:0] ST_RX_IDLE = 3'd3;
  localparam logic [2:0] ST_RX_RECV = 3'd4;
  localparam logic [2:0] ST_RX_ACK = 3'd5;
  localparam logic [2:0] ST_ERROR = 3'd6;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_TX = 3'd1;
  localparam logic [2:0] CMD_RETX = 3'd2;
  localparam logic [2:0] CMD_ARM = 3'd3;
  localparam logic [2:0] CMD_ACK = 3'd4;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_TMO_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ACK_REPEATS = 2'd2;

  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_RX = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] send_len;
    logic [1:0] link_state;
    logic       rx_ok;
    logic [7:0] rx_id;
  } item_t;

  typedef struct packed {
    logic [2:0] link_cmd;
    logic [7:0] cmd_id;
    logic [5:0] cmd_len;
    logic [2:0] proto_state;
    logic [1:0] link_state_echo;
  } result_t;

  typedef struct packed {
    logic [2:0] proto;
    logic [7:0] frame_id;
    logic [7:0] id_cnt;
    logic [7:0] tmo_left;
    logic [7:0] acks_left;
  } arq_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] tmo_limit;
    logic [7:0] ack_repeats;
  } arq_cfg_t;

endpackage

>>> rtl/stop_and_wait_arq_endpoint.sv
// Stop-and-wait ARQ endpoint top level: input register, step logic, result register.
//
// Use: in_* carries requests and periodic ticks (req_type, send_len, link_state,
// rx_ok, rx_id); out_* returns exactly one result per item: the link command,
// its frame id and length, the protocol state after the item and the echoed
// link status. cfg_* writes mode (index 0), the timeout limit (1) and
// ack_repeats (2); cfg_ready is always high and writes are expected only while
// the block is idle. A mode write puts the protocol into that mode's idle state.
// An accepted item moves from the input register into the output register unless
// a held result blocks it. Throughput: one item per cycle while no result is held;
// the protocol state is updated by a single pass of step logic when the item moves
// into the output register, so the next item sees it in the following cycle.
// Stall: when out_stall holds a result, the item in the input register waits
// and in_stall rises only if that register is occupied; nothing is dropped.
// Reset (rst_n low, synchronous): sender mode, timeout limit 20, ack_repeats 10,
// tx idle state, id counter 1, both pipeline registers empty.
module stop_and_wait_arq_endpoint (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_send_len,
  input  logic [1:0] in_link_state,
  input  logic       in_rx_ok,
  input  logic [7:0] in_rx_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_link_cmd,
  output logic [7:0] out_cmd_id,
  output logic [5:0] out_cmd_len,
  output logic [2:0] out_proto_state,
  output logic [1:0] out_link_state_echo,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sawarq_pkg::*;

  item_t      item_r;
  logic       item_valid_r;
  result_t    res_r;
  logic       out_valid_r;
  result_t    res_nxt;
  arq_state_t state_q;
  arq_state_t state_nxt;
  arq_cfg_t   cfg_q;
  logic       advance;
  logic       in_take;

  assign advance = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_take = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{req_type: in_req_type, send_len: in_send_len,
                  link_state: in_link_state, rx_ok: in_rx_ok, rx_id: in_rx_id};
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  sawarq_step u_step (
    .item (item_r),
    .cur  (state_q),
    .cfg  (cfg_q),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  sawarq_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (advance),
    .state_nxt (state_nxt),
    .state_q   (state_q),
    .cfg_q     (cfg_q)
  );

  assign out_valid = out_valid_r;
  assign out_link_cmd = res_r.link_cmd;
  assign out_cmd_id = res_r.cmd_id;
  assign out_cmd_len = res_r.cmd_len;
  assign out_proto_state = res_r.proto_state;
  assign out_link_state_echo = res_r.link_state_echo;

  // A stalled input item only waits behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // An ack always carries length 1 and ends in the rx ack state.
  a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_link_cmd == CMD_ACK) |->
      (out_cmd_len == 6'd1 && out_proto_state == ST_RX_ACK))
    else $error("malformed ack result");

  // A new data frame gets an id from the wrapping range and a bounded length.
  a_tx_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_link_cmd == CMD_TX) |->
      (out_cmd_id != 8'd0 && {1'b0, out_cmd_id} < ID_WRAP &&
       {2'b00, out_cmd_len} <= PACKET_BYTES && out_proto_state == ST_TX_SEND))
    else $error("bad transmit data result");

  // Every accepted item reaches the result register on the next advance.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost on advance");

endmodule

>>> rtl/sawarq_step.sv
// Next-state and link command logic for one item.
module sawarq_step (
  input  sawarq_pkg::item_t      item,
  input  sawarq_pkg::arq_state_t cur,
  input  sawarq_pkg::arq_cfg_t   cfg,
  output sawarq_pkg::arq_state_t nxt,
  output sawarq_pkg::result_t    res
);
  import sawarq_pkg::*;

  logic [8:0] id_inc;
  logic       link_idle;

  assign id_inc = {1'b0, cur.id_cnt} + 9'd1;
  assign link_idle = (item.link_state == LINK_IDLE);

  always_comb begin
    nxt = cur;
    res = '0;
    case (item.req_type)
      REQ_SEND: begin
        if (cfg.mode == MODE_TX) begin
          nxt.id_cnt = (id_inc >= ID_WRAP) ? ID_BASE : id_inc[7:0];
          nxt.frame_id = nxt.id_cnt;
          nxt.tmo_left = cfg.tmo_limit;
          nxt.proto = ST_TX_SEND;
          res.link_cmd = CMD_TX;
          res.cmd_id = nxt.id_cnt;
          res.cmd_len = ({2'b00, item.send_len} > PACKET_BYTES) ? PACKET_BYTES[5:0]
                                                                : item.send_len;
        end
      end
      REQ_RECV: begin
        if (cfg.mode == MODE_RX) begin
          nxt.proto = ST_RX_RECV;
          nxt.acks_left = cfg.ack_repeats;
          res.link_cmd = CMD_ARM;
        end
      end
      REQ_TICK: begin
        if (cfg.mode == MODE_RX) begin
          res.link_state_echo = item.link_state;
        end
        if (item.link_state == LINK_ERROR) begin
          nxt.proto = ST_ERROR;
        end else if (cfg.mode == MODE_TX) begin
          if (cur.proto == ST_TX_SEND) begin
            if (link_idle) begin
              res.link_cmd = CMD_ARM;
              nxt.proto = ST_TX_ACK;
            end
          end else if (cur.proto == ST_TX_ACK) begin
            if (link_idle && item.rx_ok && item.rx_id == cur.frame_id) begin
              nxt.proto = ST_TX_IDLE;
            end else if (cur.tmo_left <= 8'd1) begin
              // timeout: reload and retransmit
              nxt.tmo_left = cfg.tmo_limit;
              nxt.proto = ST_TX_SEND;
              res.link_cmd = CMD_RETX;
            end else begin
              nxt.tmo_left = cur.tmo_left - 8'd1;
              if (link_idle) begin
                res.link_cmd = CMD_ARM;
              end
            end
          end
        end else begin
          if (cur.proto == ST_RX_RECV) begin
            if (link_idle) begin
              if (!item.rx_ok) begin
                res.link_cmd = CMD_ARM;
              end else begin
                nxt.frame_id = item.rx_id;
                nxt.proto = ST_RX_ACK;
                res.link_cmd = CMD_ACK;
                res.cmd_id = item.rx_id;
                res.cmd_len = 6'd1;
              end
            end
          end else if (cur.proto == ST_RX_ACK) begin
            if (link_idle) begin
              if (cur.acks_left <= 8'd1) begin
                nxt.acks_left = 8'd0;
                nxt.proto = ST_RX_IDLE;
              end else begin
                nxt.acks_left = cur.acks_left - 8'd1;
                res.link_cmd = CMD_ACK;
                res.cmd_id = cur.frame_id;
                res.cmd_len = 6'd1;
              end
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.proto_state = nxt.proto;
  end

endmodule

>>> rtl/sawarq_regs.sv
// Configuration registers and the protocol state registers.
module sawarq_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   step_en,
  input  sawarq_pkg::arq_state_t state_nxt,
  output sawarq_pkg::arq_state_t state_q,
  output sawarq_pkg::arq_cfg_t   cfg_q
);
  import sawarq_pkg::*;

  arq_state_t state_r;
  arq_cfg_t   cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_TX;
      cfg_r.tmo_limit <= TIMEOUT_RESET;
      cfg_r.ack_repeats <= ACKS_RESET;
      state_r.proto <= ST_TX_IDLE;
      state_r.frame_id <= 8'd0;
      state_r.id_cnt <= ID_BASE;
      state_r.tmo_left <= 8'd0;
      state_r.acks_left <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE: begin
          cfg_r.mode <= cfg_data[0];
          state_r.proto <= cfg_data[0] ? ST_RX_IDLE : ST_TX_IDLE;
        end
        CFG_TMO_LIMIT: cfg_r.tmo_limit <= cfg_data;
        CFG_ACK_REPEATS: cfg_r.ack_repeats <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  assign state_q = state_r;
  assign cfg_q = cfg_r;

endmodule

>>> tb/sv/stop_and_wait_arq_endpoint_tb.sv
// Self-checking testbench for the stop-and-wait ARQ endpoint.
`timescale 1ns / 100ps

module stop_and_wait_arq_endpoint_tb;
  import sawarq_pkg::*;

  localparam logic [1:0] LINK_BUSY = 2'd1;
  localparam logic [1:0] LINK_SPARE = 2'd3;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = '0;
  logic [5:0] in_send_len = '0;
  logic [1:0] in_link_state = '0;
  logic       in_rx_ok = 1'b0;
  logic [7:0] in_rx_id = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_link_cmd;
  logic [7:0] out_cmd_id;
  logic [5:0] out_cmd_len;
  logic [2:0] out_proto_state;
  logic [1:0] out_link_state_echo;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  stop_and_wait_arq_endpoint i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_send_len, .in_link_state, .in_rx_ok, .in_rx_id,
    .out_valid, .out_stall, .out_link_cmd, .out_cmd_id, .out_cmd_len, .out_proto_state,
    .out_link_state_echo,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // Predicted endpoint state and registers
  logic       p_mode;
  logic [7:0] p_max_tmo;
  logic [7:0] p_ack_rep;
  logic [2:0] p_state;
  logic [7:0] p_frame;
  logic [7:0] p_id_cnt;
  logic [7:0] p_tmo;
  logic [7:0] p_acks;

  result_t expected_responses[$];
  int      items_sent;
  int      results_seen;
  int      mismatches;
  int      cmd_seen[8];
  int      idle_cycles;
  bit      quiet = 1'b0;
  logic    cur_mode = MODE_TX;
  logic [7:0] tx_id = ID_BASE;

  function automatic result_t arq_response(input item_t it);
    result_t r;
    r = '0;
    case (it.req_type)
      REQ_SEND: begin
        if (p_mode == MODE_TX) begin
          if ({1'b0, p_id_cnt} + 9'd1 >= ID_WRAP) p_id_cnt = ID_BASE;
          else p_id_cnt = p_id_cnt + 8'd1;
          p_frame = p_id_cnt;
          r.link_cmd = CMD_TX;
          r.cmd_id = p_frame;
          r.cmd_len = (it.send_len > PACKET_BYTES) ? PACKET_BYTES[5:0] : it.send_len;
          p_tmo = p_max_tmo;
          p_state = ST_TX_SEND;
        end
      end
      REQ_RECV: begin
        if (p_mode == MODE_RX) begin
          p_state = ST_RX_RECV;
          p_acks = p_ack_rep;
          r.link_cmd = CMD_ARM;
        end
      end
      REQ_TICK: begin
        if (p_mode == MODE_RX) r.link_state_echo = it.link_state;
        if (it.link_state == LINK_ERROR) begin
          p_state = ST_ERROR;
        end else if (p_mode == MODE_TX) begin
          if (p_state == ST_TX_SEND) begin
            if (it.link_state == LINK_IDLE) begin
              r.link_cmd = CMD_ARM;
              p_state = ST_TX_ACK;
            end
          end else if (p_state == ST_TX_ACK) begin
            if (it.link_state == LINK_IDLE && it.rx_ok && it.rx_id == p_frame) begin
              p_state = ST_TX_IDLE;
            end else if (p_tmo <= 8'd1) begin
              // timeout: reload and go back to resend
              p_tmo = p_max_tmo;
              p_state = ST_TX_SEND;
              r.link_cmd = CMD_RETX;
            end else begin
              p_tmo = p_tmo - 8'd1;
              if (it.link_state == LINK_IDLE) r.link_cmd = CMD_ARM;
            end
          end
        end else begin
          if (p_state == ST_RX_RECV && it.link_state == LINK_IDLE) begin
            if (!it.rx_ok) begin
              r.link_cmd = CMD_ARM;
            end else begin
              p_frame = it.rx_id;
              r.link_cmd = CMD_ACK;
              r.cmd_id = p_frame;
              r.cmd_len = 6'd1;
              p_state = ST_RX_ACK;
            end
          end else if (p_state == ST_RX_ACK && it.link_state == LINK_IDLE) begin
            if (p_acks <= 8'd1) begin
              p_acks = '0;
              p_state = ST_RX_IDLE;
            end else begin
              p_acks = p_acks - 8'd1;
              r.link_cmd = CMD_ACK;
              r.cmd_id = p_frame;
              r.cmd_len = 6'd1;
            end
          end
        end
      end
      default: ;
    endcase
    r.proto_state = p_state;
    return r;
  endfunction

  // Result check first, then register writes and new items, all on the same edge
  always @(posedge clk) begin : scoreboard
    result_t got, want;
    if (!rst_n) begin
      p_mode = MODE_TX;
      p_max_tmo = TIMEOUT_RESET;
      p_ack_rep = ACKS_RESET;
      p_state = ST_TX_IDLE;
      p_frame = '0;
      p_id_cnt = ID_BASE;
      p_tmo = '0;
      p_acks = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_link_cmd, out_cmd_id, out_cmd_len, out_proto_state, out_link_state_echo};
        results_seen++;
        cmd_seen[got.link_cmd]++;
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected result cmd %0d id %0d len %0d state %0d echo %0d",
                   $time, got.link_cmd, got.cmd_id, got.cmd_len, got.proto_state,
                   got.link_state_echo);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          if (got !== want) begin
            if (got.link_cmd !== want.link_cmd)
              $display("%0t: link_cmd expected %0d actual %0d", $time, want.link_cmd,
                       got.link_cmd);
            if (got.cmd_id !== want.cmd_id)
              $display("%0t: cmd_id expected %0d actual %0d", $time, want.cmd_id, got.cmd_id);
            if (got.cmd_len !== want.cmd_len)
              $display("%0t: cmd_len expected %0d actual %0d", $time, want.cmd_len,
                       got.cmd_len);
            if (got.proto_state !== want.proto_state)
              $display("%0t: proto_state expected %0d actual %0d", $time, want.proto_state,
                       got.proto_state);
            if (got.link_state_echo !== want.link_state_echo)
              $display("%0t: link_state_echo expected %0d actual %0d", $time,
                       want.link_state_echo, got.link_state_echo);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: begin
            p_mode = cfg_data[0];
            p_state = cfg_data[0] ? ST_RX_IDLE : ST_TX_IDLE;
          end
          CFG_TMO_LIMIT: p_max_tmo = cfg_data;
          CFG_ACK_REPEATS: p_ack_rep = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_responses.push_back(arq_response({in_req_type, in_send_len, in_link_state,
                                                   in_rx_ok, in_rx_id}));
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAIL stop_and_wait_arq_endpoint");
      $finish;
    end
  end

  function automatic item_t make_item(input logic [1:0] req, input logic [5:0] len,
                                      input logic [1:0] link, input logic ok,
                                      input logic [7:0] id);
    item_t it;
    it.req_type = req;
    it.send_len = len;
    it.link_state = link;
    it.rx_ok = ok;
    it.rx_id = id;
    return it;
  endfunction

  function automatic logic [1:0] pick_link(input int idle_pct);
    int l;
    l = $urandom_range(99);
    if (l < idle_pct) return LINK_IDLE;
    if (l < idle_pct + (100 - idle_pct) / 2) return LINK_BUSY;
    if (l < 95) return LINK_SPARE;
    return LINK_ERROR;
  endfunction

  task automatic send_item(input item_t it);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_send_len <= it.send_len;
    in_link_state <= it.link_state;
    in_rx_ok <= it.rx_ok;
    in_rx_id <= it.rx_id;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // track the id of the frame in flight so acks can match it
    if (it.req_type == REQ_SEND && cur_mode == MODE_TX)
      tx_id = (tx_id >= 8'd249) ? ID_BASE : tx_id + 8'd1;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic md, input logic [7:0] tmo, input logic [7:0] acks);
    wait_drained();
    put_reg(CFG_MODE, {7'd0, md});
    put_reg(CFG_TMO_LIMIT, tmo);
    put_reg(CFG_ACK_REPEATS, acks);
    cfg_valid <= 1'b0;
    cur_mode = md;
  endtask

  // Reset defaults: sender mode, timeout 20
  task automatic test_sender_basics();
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, 8'd0));
    send_item(make_item(REQ_SEND, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_BUSY, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, tx_id));
    send_item(make_item(REQ_SEND, 6'd63, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, 8'd255));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, tx_id));
    send_item(make_item(REQ_TICK, 6'd0, LINK_SPARE, 1'b1, tx_id));
    send_item(make_item(REQ_RECV, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_SPARE, 6'd63, LINK_IDLE, 1'b1, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_ERROR, 1'b1, tx_id));
    send_item(make_item(REQ_SEND, 6'd33, LINK_IDLE, 1'b0, 8'd0));
  endtask

  task automatic test_sender_timeout();
    program_regs(MODE_TX, 8'd2, ACKS_RESET);
    send_item(make_item(REQ_SEND, 6'd32, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_BUSY, 1'b1, tx_id));
    send_item(make_item(REQ_TICK, 6'd0, LINK_BUSY, 1'b1, tx_id));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, tx_id));
  endtask

  task automatic test_receiver_basics();
    program_regs(MODE_RX, 8'd255, 8'd2);
    send_item(make_item(REQ_SEND, 6'd5, LINK_IDLE, 1'b1, 8'd0));
    send_item(make_item(REQ_RECV, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_BUSY, 1'b1, 8'd7));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd7));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, 8'd255));
    send_item(make_item(REQ_TICK, 6'd0, LINK_SPARE, 1'b1, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_ERROR, 1'b1, 8'd0));
    send_item(make_item(REQ_RECV, 6'd0, LINK_IDLE, 1'b0, 8'd0));
    send_item(make_item(REQ_TICK, 6'd0, LINK_IDLE, 1'b1, 8'd0));
  endtask

  // Mostly send/arm/ack exchanges, with busy links, bad acks and errors mixed in
  task automatic test_sender_random(input int n, input logic [7:0] tmo, input int send_pct);
    int r;
    logic [5:0] len;
    program_regs(MODE_TX, tmo, ACKS_RESET);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      len = ($urandom_range(99) < 85) ? 6'($urandom_range(32)) : 6'($urandom_range(63));
      if (r < send_pct)
        send_item(make_item(REQ_SEND, len, pick_link(70), 1'($urandom_range(1)),
                            8'($urandom)));
      else if (r < send_pct + 2)
        send_item(make_item(r[0] ? REQ_RECV : REQ_SPARE, len, pick_link(70),
                            1'($urandom_range(1)), 8'($urandom)));
      else
        send_item(make_item(REQ_TICK, len, pick_link(70), $urandom_range(99) < 85,
                            ($urandom_range(99) < 75) ? tx_id : 8'($urandom)));
    end
  endtask

  // Send-heavy run with no idling so the frame id counter wraps
  task automatic test_frame_id_wrap(input int n);
    quiet = 1'b1;
    test_sender_random(n, 8'd0, 75);
    quiet = 1'b0;
  endtask

  task automatic test_receiver_random(input int n, input logic [7:0] acks);
    int r;
    program_regs(MODE_RX, 8'($urandom), acks);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10)
        send_item(make_item(REQ_RECV, 6'($urandom), pick_link(75), 1'($urandom_range(1)),
                            8'($urandom)));
      else if (r < 14)
        send_item(make_item(r[0] ? REQ_SEND : REQ_SPARE, 6'($urandom), pick_link(75),
                            1'($urandom_range(1)), 8'($urandom)));
      else
        send_item(make_item(REQ_TICK, 6'($urandom), pick_link(75), $urandom_range(99) < 70,
                            8'($urandom)));
    end
  endtask

  task automatic test_mixed_noise(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) program_regs(1'($urandom_range(1)), 8'($urandom), 8'($urandom));
      it = item_t'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sender_basics();
    test_sender_timeout();
    test_receiver_basics();
    test_sender_random(250, 8'd3, 15);
    test_sender_random(200, 8'd255, 15);
    test_frame_id_wrap(300);
    test_receiver_random(200, 8'd1);
    test_receiver_random(150, 8'd255);
    test_receiver_random(100, 8'd0);
    test_mixed_noise(100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_responses.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_responses.size());
      mismatches++;
    end
    $display("Ran %0d items through sender, receiver and mixed phases, incl. id wrap",
             items_sent);
    $display("Commands: none %0d tx %0d retx %0d arm %0d ack %0d, mismatches %0d",
             cmd_seen[CMD_NONE], cmd_seen[CMD_TX], cmd_seen[CMD_RETX], cmd_seen[CMD_ARM],
             cmd_seen[CMD_ACK], mismatches);
    if (mismatches == 0) begin
      $display("PASS stop_and_wait_arq_endpoint");
    end else begin
      $display("FAIL stop_and_wait_arq_endpoint");
    end
    $finish;
  end

endmodule
